[design/nmea_pkg.sv]
`default_nettype none
package nmea_pkg;

    // character codes seen on the serial stream
    localparam logic [7:0] NMEA_DOLLAR = 8'h24;
    localparam logic [7:0] NMEA_STAR   = 8'h2A;
    localparam logic [7:0] NMEA_LF     = 8'h0A;

    // header length and saturation limit of the line counter
    localparam logic [2:0] NMEA_HDR_LEN   = 3'd6;
    localparam logic [7:0] NMEA_LEN_MAX   = 8'hFF;
    localparam logic [7:0] NMEA_MIN_RESET = 8'd49;

    // sentence kind codes
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GLL   = 2'd2;

    // header_match bit positions
    localparam int unsigned MATCH_RMC = 0;
    localparam int unsigned MATCH_GLL = 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_TAIL
    } t_phase;

    // expected "$GPRMC" byte at a header position
    function automatic logic [7:0] nmea_hdr_rmc(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // expected "$GPGLL" byte at a header position
    function automatic logic [7:0] nmea_hdr_gll(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h47;
            3'd4:    ch = 8'h4C;
            3'd5:    ch = 8'h4C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // uppercase hex digit decode: bit 4 set means not a digit
    function automatic logic [4:0] nmea_hex(input logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[design/nmea_byte_if.sv]
`default_nettype none
interface nmea_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[design/nmea_cfg_if.sv]
`default_nettype none
interface nmea_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] min_length;

    modport source (output valid, output min_length, input ready);
    modport sink (input valid, input min_length, output ready);
endinterface
`default_nettype wire

[design/nmea_result_if.sv]
`default_nettype none
interface nmea_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] sentence_kind;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] line_length;
    logic       star_seen;

    modport source (
        output valid, output sentence_kind, output checksum_ok,
        output computed_sum, output line_length, output star_seen,
        input ready
    );
    modport sink (
        input valid, input sentence_kind, input checksum_ok,
        input computed_sum, input line_length, input star_seen,
        output ready
    );
endinterface
`default_nettype wire

[design/nmea_sentence_checker.sv]
// channel   dir  payload                                     request taken when
// i_rx      in   rx_byte[7:0]                                valid && ready
// i_cfg     in   min_length[7:0]                             valid && ready (ready stays high)
// o_res     out  sentence_kind, checksum_ok, computed_sum,   valid && ready
//                line_length, star_seen
//
// One byte per cycle. Each byte updates the sentence state in the cycle it is
// taken; a line feed closing a sentence loads the result register, and the
// result is shown on the next cycle. i_rx.ready drops only while the result
// register is full and o_res.ready is low. Reset (synchronous, active low)
// returns to idle and sets min_length to 49.
`default_nettype none
module nmea_sentence_checker
    import nmea_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    nmea_byte_if.sink    i_rx,
    nmea_cfg_if.sink     i_cfg,
    nmea_result_if.source o_res
);

    // sentence state
    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [3:0] r_hi_nib, n_hi_nib;
    logic [7:0] r_rx_sum, n_rx_sum;
    logic       r_hex_valid, n_hex_valid;
    logic [2:0] r_hdr_pos, n_hdr_pos;
    logic [1:0] r_hdr_match, n_hdr_match;
    logic [7:0] r_len, n_len;
    logic       r_star, n_star;
    logic [7:0] r_min_length;

    // result register
    logic       r_out_valid;
    logic [1:0] r_kind, n_kind;
    logic       r_ok, n_ok;
    logic [7:0] r_sum;
    logic [7:0] r_res_len;
    logic       r_res_star;
    logic       w_emit;

    logic       w_rx_acc;
    logic [7:0] w_c;
    logic [4:0] w_hex;
    logic       w_is_dollar;
    logic       w_is_lf;
    logic       w_is_star;

    assign w_c         = i_rx.rx_byte;
    assign w_hex       = nmea_hex(w_c);
    assign w_is_dollar = (w_c == NMEA_DOLLAR);
    assign w_is_lf     = (w_c == NMEA_LF);
    assign w_is_star   = (w_c == NMEA_STAR);

    // input stalls only when a result is waiting and not being taken
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_rx_acc   = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_rx_acc) begin
            if (w_is_dollar) begin
                n_phase = PH_BODY;
            end else if (r_phase != PH_IDLE) begin
                if (w_is_lf) begin
                    n_phase = PH_IDLE;
                end else begin
                    case (r_phase)
                        PH_BODY:   if (w_is_star) n_phase = PH_HEX_HI;
                        PH_HEX_HI: n_phase = PH_HEX_LO;
                        PH_HEX_LO: n_phase = PH_TAIL;
                        default:   n_phase = r_phase;
                    endcase
                end
            end
        end
    end

    // sentence datapath and result build
    always_comb begin
        n_xor       = r_xor;
        n_hi_nib    = r_hi_nib;
        n_rx_sum    = r_rx_sum;
        n_hex_valid = r_hex_valid;
        n_hdr_pos   = r_hdr_pos;
        n_hdr_match = r_hdr_match;
        n_len       = r_len;
        n_star      = r_star;
        n_kind      = KIND_OTHER;
        n_ok        = 1'b0;
        w_emit      = 1'b0;
        if (w_rx_acc) begin
            if (w_is_dollar) begin
                // new sentence, the dollar sign counts as first byte
                n_xor       = '0;
                n_hi_nib    = '0;
                n_rx_sum    = '0;
                n_hex_valid = 1'b0;
                n_hdr_pos   = 3'd1;
                n_hdr_match = 2'b11;
                n_len       = 8'd1;
                n_star      = 1'b0;
            end else if (r_phase != PH_IDLE) begin
                if (w_is_lf) begin
                    // close the sentence
                    w_emit = 1'b1;
                    n_ok   = (r_phase == PH_TAIL) && r_hex_valid && (r_rx_sum == r_xor);
                    if ((r_hdr_pos == NMEA_HDR_LEN) && r_star && (r_len > r_min_length)) begin
                        if (r_hdr_match[MATCH_RMC]) begin
                            n_kind = KIND_RMC;
                        end else if (r_hdr_match[MATCH_GLL]) begin
                            n_kind = KIND_GLL;
                        end
                    end
                end else begin
                    if (r_len != NMEA_LEN_MAX) n_len = r_len + 8'd1;
                    // header compare against both candidates
                    if (r_hdr_pos != NMEA_HDR_LEN) begin
                        if (w_c != nmea_hdr_rmc(r_hdr_pos)) n_hdr_match[MATCH_RMC] = 1'b0;
                        if (w_c != nmea_hdr_gll(r_hdr_pos)) n_hdr_match[MATCH_GLL] = 1'b0;
                        n_hdr_pos = r_hdr_pos + 3'd1;
                    end
                    case (r_phase)
                        PH_BODY: begin
                            if (w_is_star) begin
                                n_star      = 1'b1;
                                n_hex_valid = 1'b1;
                            end else begin
                                n_xor = r_xor ^ w_c;
                            end
                        end
                        PH_HEX_HI: begin
                            if (w_hex[4]) n_hex_valid = 1'b0;
                            n_hi_nib = w_hex[4] ? 4'h0 : w_hex[3:0];
                        end
                        PH_HEX_LO: begin
                            if (w_hex[4]) n_hex_valid = 1'b0;
                            n_rx_sum = {r_hi_nib, (w_hex[4] ? 4'h0 : w_hex[3:0])};
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_xor        <= '0;
            r_hi_nib     <= '0;
            r_rx_sum     <= '0;
            r_hex_valid  <= 1'b0;
            r_hdr_pos    <= '0;
            r_hdr_match  <= 2'b11;
            r_len        <= '0;
            r_star       <= 1'b0;
            r_min_length <= NMEA_MIN_RESET;
        end else begin
            r_phase     <= n_phase;
            r_xor       <= n_xor;
            r_hi_nib    <= n_hi_nib;
            r_rx_sum    <= n_rx_sum;
            r_hex_valid <= n_hex_valid;
            r_hdr_pos   <= n_hdr_pos;
            r_hdr_match <= n_hdr_match;
            r_len       <= n_len;
            r_star      <= n_star;
            if (i_cfg.valid && i_cfg.ready) r_min_length <= i_cfg.min_length;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind     <= n_kind;
            r_ok       <= n_ok;
            r_sum      <= r_xor;
            r_res_len  <= r_len;
            r_res_star <= r_star;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.sentence_kind = r_kind;
    assign o_res.checksum_ok   = r_ok;
    assign o_res.computed_sum  = r_sum;
    assign o_res.line_length   = r_res_len;
    assign o_res.star_seen     = r_res_star;

    // a line feed closing an open sentence always yields a result
    a_lf_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rx_acc && w_is_lf && r_phase != PH_IDLE) |=> o_res.valid)
        else $error("closing line feed gave no result");

    // accepted kind needs a star
    a_kind_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.sentence_kind != KIND_OTHER) |-> o_res.star_seen)
        else $error("sentence kind reported without star");

    // checksum can only match after a star
    a_ok_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.checksum_ok) |-> o_res.star_seen)
        else $error("checksum ok without star");

    // a dollar sign always opens the body
    a_dollar_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rx_acc && w_is_dollar) |=> (r_phase == PH_BODY && r_len == 8'd1))
        else $error("dollar sign did not start a sentence");

endmodule
`default_nettype wire
